@@ rtl/cpq_pkg.sv @@
package cpq_pkg;

  // Default depth of the vertex table.
  localparam int MAX_VERTICES_DEF = 16;

  // Below this many vertices an add always succeeds without a convexity check.
  localparam int MIN_FREE_ADD = 3;

  localparam int COORD_W = 16;
  localparam int VTX_W   = 2 * COORD_W;
  localparam int OPND_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * OPND_W;
  localparam int SUM_W   = PROD_W + 1;

  // Item kinds carried on the input channel.
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef enum logic {
    OP_CROSS,
    OP_DIST
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     last;
  } op_tag_t;

  // One request to the shared multiply-add unit: a1*b1 +/- a2*b2.
  typedef struct packed {
    logic                      valid;
    op_tag_t                   tag;
    logic                      sub;
    logic signed [OPND_W-1:0]  a1;
    logic signed [OPND_W-1:0]  b1;
    logic signed [OPND_W-1:0]  a2;
    logic signed [OPND_W-1:0]  b2;
  } mac_op_t;

  typedef struct packed {
    logic                     valid;
    op_tag_t                  tag;
    logic signed [SUM_W-1:0]  sum;
  } mac_res_t;

endpackage

@@ rtl/convex_polygon_point_query.sv @@
// Convex polygon point query.
//
// The input channel carries one word per item: the kind on in_tuser (add vertex,
// query point, clear table) and the point on in_tdata. Every item produces exactly
// one result word on the output channel, held in an output register until taken.
// An add appends the point unconditionally while fewer than three vertices are
// held, is refused when the table is full, and otherwise is kept only if all
// corners of the enlarged polygon turn the same way. A query reports whether the
// point is inside or on the polygon and the index of the first nearest vertex.
// A clear, a refused or early add and a query on an empty table skip the table walk
// and go straight to the result; a checked add walks the n stored vertices through
// the corner test, and a query walks them for edge products and distances. The
// shared two-product multiply-add unit handles one corner per cycle on an add, and
// one edge product plus one squared distance per vertex on a query. The result word
// appears on the output channel in the cycle in which in_tready returns high. The block
// takes one item at a time: in_tready is low from acceptance until the result is
// loaded into the output register. A stalled receiver holds the result word, and
// the next item's result waits until that word is taken. After reset the table is
// empty and the output channel is idle.
module convex_polygon_point_query #(
  parameter int MAX_VERTICES = cpq_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // point_x [15:0], point_y [31:16]
  input  logic [1:0]  in_tuser,   // kind [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // accepted [0], inside_res [1], nearest_index [5:2],
                                  // count_now [10:6], zero fill [15:11]
);
  import cpq_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int JW = $clog2(MAX_VERTICES + 3);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t                    state_r;
  logic [1:0]                kind_r;
  logic signed [COORD_W-1:0] px_r;
  logic signed [COORD_W-1:0] py_r;
  logic [CW-1:0]             count_r;
  logic [JW-1:0]             j_r;
  logic                      ph_r;

  // Fetch-to-data stage: one vertex word becomes available per fetch.
  logic                      fv_r;
  logic                      fsrc_in_r;
  logic [JW-1:0]             fj_r;

  // Sliding window of points for the corner test on an add.
  logic signed [COORD_W-1:0] wa_x_r, wa_y_r, wb_x_r, wb_y_r;
  // Previous vertex relative to the query point, and a pending distance.
  logic signed [OPND_W-1:0]  rp_x_r, rp_y_r;
  logic                      dist_pend_r;
  logic signed [OPND_W-1:0]  dd_x_r, dd_y_r;

  // Result trackers.
  logic                      have_first_r;
  logic                      first_neg_r;
  logic                      fail_r;
  logic [AW-1:0]             dist_cnt_r;
  logic [AW-1:0]             best_idx_r;
  logic [PROD_W-1:0]         best_d_r;

  logic                      out_valid_r;
  logic [15:0]               out_data_r;

  logic                      in_fire;
  logic                      is_add;
  logic [JW-1:0]             n_j;
  logic [JW-1:0]             j_last_add;
  logic                      fetch;
  logic                      fsrc_in;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [VTX_W-1:0]          rd_data;
  logic                      walk_end;
  logic                      wr_en;
  logic                      out_free;
  logic signed [COORD_W-1:0] c_x, c_y;
  logic signed [OPND_W-1:0]  rx, ry;
  logic                      cross_v;
  logic                      cross_last;
  mac_op_t                   mac_op;
  mac_res_t                  mac_res;
  logic                      commit_add;
  logic [CW-1:0]             count_fin;
  logic                      res_acc, res_inside;
  logic [3:0]                res_near;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign is_add    = (kind_r == KIND_ADD);
  assign n_j        = JW'(count_r);
  assign j_last_add = n_j + JW'(2);
  assign out_free   = !out_valid_r || out_tready;

  // Fetch sequencing. An add streams new, V0..Vn-1, new, V0 one per cycle; a query
  // streams V0..Vn-1, V0, fetching only while ph_r is low.
  always_comb begin
    fetch   = 1'b0;
    fsrc_in = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state_r == S_WALK) begin
      if (is_add) begin
        fetch   = 1'b1;
        fsrc_in = (j_r == '0) || (j_r == n_j + JW'(1));
        rd_en   = !fsrc_in;
        rd_addr = (j_r == j_last_add) ? '0 : AW'(j_r - JW'(1));
      end else if (!ph_r) begin
        fetch   = 1'b1;
        rd_en   = 1'b1;
        rd_addr = (j_r == n_j) ? '0 : AW'(j_r);
      end
    end
  end

  assign walk_end = fetch && (is_add ? (j_r == j_last_add) : (j_r == n_j));

  // Data stage: build the operands for the shared unit.
  always_comb begin
    c_x = fsrc_in_r ? px_r : rd_data[COORD_W-1:0];
    c_y = fsrc_in_r ? py_r : rd_data[VTX_W-1:COORD_W];
    rx  = {c_x[COORD_W-1], c_x} - {px_r[COORD_W-1], px_r};
    ry  = {c_y[COORD_W-1], c_y} - {py_r[COORD_W-1], py_r};
    cross_v    = fv_r && (is_add ? (fj_r >= JW'(2)) : (fj_r >= JW'(1)));
    cross_last = is_add ? (fj_r == j_last_add) : (fj_r == n_j);

    mac_op.valid    = dist_pend_r;
    mac_op.tag.kind = OP_DIST;
    mac_op.tag.last = 1'b0;
    mac_op.sub      = 1'b0;
    mac_op.a1       = dd_x_r;
    mac_op.b1       = dd_x_r;
    mac_op.a2       = dd_y_r;
    mac_op.b2       = dd_y_r;
    if (cross_v) begin
      mac_op.valid    = 1'b1;
      mac_op.tag.kind = OP_CROSS;
      mac_op.tag.last = cross_last;
      mac_op.sub      = 1'b1;
      if (is_add) begin
        // Corner at b: (c - b) x (a - b).
        mac_op.a1 = {c_x[COORD_W-1], c_x} - {wb_x_r[COORD_W-1], wb_x_r};
        mac_op.b1 = {wa_y_r[COORD_W-1], wa_y_r} - {wb_y_r[COORD_W-1], wb_y_r};
        mac_op.a2 = {wa_x_r[COORD_W-1], wa_x_r} - {wb_x_r[COORD_W-1], wb_x_r};
        mac_op.b2 = {c_y[COORD_W-1], c_y} - {wb_y_r[COORD_W-1], wb_y_r};
      end else begin
        // Edge seen from the query point: prev x cur.
        mac_op.a1 = rp_x_r;
        mac_op.b1 = ry;
        mac_op.a2 = rx;
        mac_op.b2 = rp_y_r;
      end
    end
  end

  // Result of the item, formed when it finishes.
  always_comb begin
    commit_add = is_add && !fail_r;
    count_fin  = count_r;
    if (commit_add) begin
      count_fin = count_r + CW'(1);
    end else if (kind_r == KIND_CLEAR) begin
      count_fin = '0;
    end
    res_acc    = is_add ? !fail_r : 1'b1;
    res_inside = (kind_r == KIND_QUERY) && !fail_r;
    res_near   = (kind_r == KIND_QUERY) ? 4'(best_idx_r) : 4'd0;
  end

  assign wr_en = (state_r == S_FINISH) && out_free && commit_add;

  cpq_vtx_mem #(
    .DEPTH (MAX_VERTICES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(count_r)),
    .wr_data ({py_r, px_r}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cpq_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op_i  (mac_op),
    .res_o (mac_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fv_r        <= 1'b0;
      dist_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      ph_r        <= 1'b0;
    end else begin
      fv_r <= fetch;
      if (fetch) begin
        fsrc_in_r <= fsrc_in;
        fj_r      <= j_r;
        j_r       <= j_r + JW'(1);
      end
      if (state_r == S_WALK && !is_add) begin
        ph_r <= !ph_r;
      end

      // Data stage bookkeeping. A pending distance is always issued in the cycle
      // after its vertex arrives, since no query vertex arrives in that cycle.
      dist_pend_r <= fv_r && !is_add && (fj_r < n_j);
      if (fv_r) begin
        if (is_add) begin
          wa_x_r <= wb_x_r;
          wa_y_r <= wb_y_r;
          wb_x_r <= c_x;
          wb_y_r <= c_y;
        end else begin
          rp_x_r <= rx;
          rp_y_r <= ry;
          if (fj_r < n_j) begin
            dd_x_r <= rx;
            dd_y_r <= ry;
          end
        end
      end

      // Results of the shared unit.
      if (mac_res.valid) begin
        if (mac_res.tag.kind == OP_CROSS) begin
          if (mac_res.sum != '0) begin
            if (!have_first_r) begin
              have_first_r <= 1'b1;
              first_neg_r  <= mac_res.sum[SUM_W-1];
            end else if (mac_res.sum[SUM_W-1] != first_neg_r) begin
              fail_r <= 1'b1;
            end
          end
        end else begin
          if (dist_cnt_r == '0 || mac_res.sum[PROD_W-1:0] < best_d_r) begin
            best_idx_r <= dist_cnt_r;
            best_d_r   <= mac_res.sum[PROD_W-1:0];
          end
          dist_cnt_r <= dist_cnt_r + AW'(1);
        end
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kind_r       <= in_tuser;
            px_r         <= in_tdata[15:0];
            py_r         <= in_tdata[31:16];
            j_r          <= '0;
            ph_r         <= 1'b0;
            have_first_r <= 1'b0;
            first_neg_r  <= 1'b0;
            fail_r       <= 1'b0;
            dist_cnt_r   <= '0;
            best_idx_r   <= '0;
            best_d_r     <= '0;
            state_r      <= S_FINISH;
            if (in_tuser == KIND_ADD) begin
              if (count_r >= CW'(MAX_VERTICES)) begin
                fail_r <= 1'b1;
              end else if (count_r >= CW'(MIN_FREE_ADD)) begin
                state_r <= S_WALK;
              end
            end else if (in_tuser == KIND_QUERY && count_r != '0) begin
              state_r <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (walk_end) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (mac_res.valid && mac_res.tag.last) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            count_r     <= count_fin;
            out_valid_r <= 1'b1;
            out_data_r  <= {5'd0, 5'(count_fin), res_near, res_inside, res_acc};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/cpq_vtx_mem.sv @@
module cpq_vtx_mem #(
  parameter int DEPTH = cpq_pkg::MAX_VERTICES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [cpq_pkg::VTX_W-1:0]  wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [cpq_pkg::VTX_W-1:0]  rd_data
);
  import cpq_pkg::*;

  logic [VTX_W-1:0] mem [DEPTH];
  logic [VTX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/cpq_mac.sv @@
module cpq_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  cpq_pkg::mac_op_t  op_i,
  output cpq_pkg::mac_res_t res_o
);
  import cpq_pkg::*;

  // Stage one registers both products, stage two their sum or difference.
  logic                     m_valid_r;
  op_tag_t                  m_tag_r;
  logic                     m_sub_r;
  logic signed [PROD_W-1:0] p1_r;
  logic signed [PROD_W-1:0] p2_r;
  logic                     s_valid_r;
  op_tag_t                  s_tag_r;
  logic signed [SUM_W-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else begin
      m_valid_r <= op_i.valid;
      s_valid_r <= m_valid_r;
    end
    m_tag_r <= op_i.tag;
    m_sub_r <= op_i.sub;
    p1_r    <= op_i.a1 * op_i.b1;
    p2_r    <= op_i.a2 * op_i.b2;
    s_tag_r <= m_tag_r;
    sum_r   <= m_sub_r ? (SUM_W'(p1_r) - SUM_W'(p2_r)) : (SUM_W'(p1_r) + SUM_W'(p2_r));
  end

  always_comb begin
    res_o.valid = s_valid_r;
    res_o.tag   = s_tag_r;
    res_o.sum   = sum_r;
  end

endmodule

@@ rtl/cpq_chk.sv @@
module cpq_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A result word waiting for the receiver holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an item is in progress");

  // Only a query reports inside or a nearest vertex, and a query is always accepted.
  a_query_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1] || out_tdata[5:2] != 4'd0) |-> out_tdata[0])
    else $error("query fields set on a refused add");

  // Reset leaves the block ready with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind convex_polygon_point_query cpq_chk u_cpq_chk (.*);
